@@ rtl/gpdb_pkg.sv @@
// Package with types, constants and the protection class table for the descriptor builder.
`default_nettype none
package gpdb_pkg;

  localparam int unsigned PAGE_BITS           = 14;
  localparam int unsigned OUTPUT_ADDRESS_BITS = 40;
  localparam int unsigned INPUT_ADDRESS_BITS  = 39;
  localparam int unsigned CONTEXT_COUNT       = 64;

  localparam int unsigned AddrW = 64;
  localparam int unsigned CtxW  = 8;
  localparam int unsigned ProtW = 4;

  localparam int unsigned BitOwner  = 55;
  localparam int unsigned BitUxn    = 54;
  localparam int unsigned BitPxn    = 53;
  localparam int unsigned BitNg     = 11;
  localparam int unsigned BitAf     = 10;
  localparam int unsigned AsidShift = 48;

  localparam logic [1:0] TypeBits  = 2'b11;
  localparam logic       BaseValid = 1'b1;

  typedef enum logic [1:0] {
    OP_PAGE     = 2'd0,
    OP_TABLE    = 2'd1,
    OP_BASE     = 2'd2,
    OP_VALIDATE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_INVALID      = 3'd1,
    ST_BAD_CONTEXT  = 3'd2,
    ST_BAD_PROT     = 3'd3,
    ST_MISALIGNED   = 3'd4,
    ST_OUT_OF_RANGE = 3'd5,
    ST_OVERFLOW     = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0] attr;
    logic [1:0] ap;
    logic       uxn;
    logic       pxn;
  } class_bits_t;

  // Classes zero to four belong to the firmware context, five to seven to the others.
  function automatic class_bits_t class_lookup(input logic [2:0] idx);
    class_bits_t c;
    case (idx)
      3'd0:    c = '{attr: 2'd1, ap: 2'd1, uxn: 1'b1, pxn: 1'b0};
      3'd1:    c = '{attr: 2'd2, ap: 2'd1, uxn: 1'b1, pxn: 1'b0};
      3'd2:    c = '{attr: 2'd0, ap: 2'd1, uxn: 1'b1, pxn: 1'b0};
      3'd3:    c = '{attr: 2'd0, ap: 2'd0, uxn: 1'b1, pxn: 1'b1};
      3'd4:    c = '{attr: 2'd0, ap: 2'd1, uxn: 1'b1, pxn: 1'b1};
      3'd5:    c = '{attr: 2'd2, ap: 2'd2, uxn: 1'b0, pxn: 1'b0};
      3'd6:    c = '{attr: 2'd2, ap: 2'd2, uxn: 1'b0, pxn: 1'b1};
      3'd7:    c = '{attr: 2'd2, ap: 2'd2, uxn: 1'b1, pxn: 1'b0};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/gpu_page_descriptor_builder.sv @@
// Top level of the translation-table word builder: input register, check and pack logic,
// result register.
//
// Accepts one request transfer every clock cycle while the output side does not stall, and returns
// exactly one result transfer per request. Each request passes through the input register and
// then the result register; between them sits one level of 64-bit adds and
// compares. The output stalls without loss: the input register holds while the result
// register waits. The firmware context register is written with cfg_wr_en_i and must only be
// changed while no request is in flight.
`default_nettype none
module gpu_page_descriptor_builder (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_wr_en_i,
  input  wire logic [7:0]   cfg_wr_data_i,   // firmware_context_id
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata from bit 0: context_req[7:0], protection[3:0], physical_address[63:0],
  // high_root_address[63:0], virtual_address[63:0], length[63:0], 4 zero bits
  input  wire logic [271:0] s_axis_tdata,
  input  wire logic [1:0]   s_axis_tuser,    // operation
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata from bit 0: descriptor[63:0], high_base_word[63:0], half, 7 zero bits
  output logic [135:0]      m_axis_tdata,
  output logic [2:0]        m_axis_tuser     // status
);

  localparam int unsigned AW  = gpdb_pkg::AddrW;
  localparam int unsigned PB  = gpdb_pkg::PAGE_BITS;
  localparam int unsigned OAB = gpdb_pkg::OUTPUT_ADDRESS_BITS;
  localparam int unsigned IAB = gpdb_pkg::INPUT_ADDRESS_BITS;
  localparam logic [AW:0] PhysLimit = (AW+1)'(1) << OAB;
  localparam logic [AW:0] LowLimit  = (AW+1)'(1) << IAB;

  // Configuration register
  logic [7:0] fw_ctx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_ctx_q <= '0;
    end else if (cfg_wr_en_i) begin
      fw_ctx_q <= cfg_wr_data_i;
    end
  end

  // Handshake and stage control
  logic in_valid_q, out_valid_q;
  logic out_adv, in_acc;

  assign out_adv       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_valid_q <= 1'b1;
      end else if (out_adv) begin
        in_valid_q <= 1'b0;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Input register
  gpdb_pkg::op_e                   op_q;
  logic [gpdb_pkg::CtxW-1:0]       ctx_q;
  logic [gpdb_pkg::ProtW-1:0]      prot_q;
  logic [AW-1:0]                   pa_q, pa_hi_q, va_q, len_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= gpdb_pkg::op_e'(s_axis_tuser);
      ctx_q   <= s_axis_tdata[7:0];
      prot_q  <= s_axis_tdata[11:8];
      pa_q    <= s_axis_tdata[75:12];
      pa_hi_q <= s_axis_tdata[139:76];
      va_q    <= s_axis_tdata[203:140];
      len_q   <= s_axis_tdata[267:204];
    end
  end

  // Leaf attribute bits and their checks
  gpdb_pkg::class_bits_t cls;
  logic                  is_fw, ctx_bad, prot_bad;
  logic [AW-1:0]         leaf;

  assign cls     = gpdb_pkg::class_lookup(prot_q[2:0]);
  assign is_fw   = (ctx_q == fw_ctx_q);
  assign ctx_bad = ({1'b0, ctx_q} >= 9'(gpdb_pkg::CONTEXT_COUNT));
  assign prot_bad = prot_q[3] ||
                    (is_fw && (prot_q[2:0] >= 3'd5)) ||
                    (!is_fw && (prot_q[2:0] <= 3'd4));

  always_comb begin
    leaf                      = '0;
    leaf[gpdb_pkg::BitOwner]  = 1'b1;
    leaf[gpdb_pkg::BitUxn]    = cls.uxn;
    leaf[gpdb_pkg::BitPxn]    = cls.pxn;
    leaf[gpdb_pkg::BitNg]     = !is_fw;
    leaf[gpdb_pkg::BitAf]     = 1'b1;
    leaf[7:6]                 = cls.ap;
    leaf[3:2]                 = cls.attr;
    leaf[1:0]                 = gpdb_pkg::TypeBits;
  end

  // Address checks
  logic pa_mis, pa_oor, hi_mis, hi_oor, rng_mis;
  logic [AW:0] va_end, pa_end;
  logic        wrap, pa_end_oor, va_low, end_low, va_high;

  assign pa_mis  = |pa_q[PB-1:0];
  assign pa_oor  = |pa_q[AW-1:OAB];
  assign hi_mis  = |pa_hi_q[PB-1:0];
  assign hi_oor  = |pa_hi_q[AW-1:OAB];
  assign rng_mis = |(va_q[PB-1:0] | pa_q[PB-1:0] | len_q[PB-1:0]);

  // va_end and pa_end are one past the last byte of each range.
  assign va_end     = {1'b0, va_q} + {1'b0, len_q};
  assign pa_end     = {1'b0, pa_q} + {1'b0, len_q};
  assign wrap       = va_end[AW] && (|va_end[AW-1:0]);
  assign pa_end_oor = (pa_end > PhysLimit);
  assign va_low     = ~|va_q[AW-1:IAB];
  assign end_low    = (va_end <= LowLimit);
  assign va_high    = &va_q[AW-1:IAB];

  // Result selection with the error precedence of each job
  gpdb_pkg::status_e st;
  logic [AW-1:0]     desc, hi_word, asid;
  logic              half;

  assign asid = AW'(ctx_q) << gpdb_pkg::AsidShift;

  always_comb begin
    st      = gpdb_pkg::ST_OK;
    desc    = '0;
    hi_word = '0;
    half    = 1'b0;
    case (op_q)
      gpdb_pkg::OP_PAGE: begin
        if (ctx_bad)       st = gpdb_pkg::ST_BAD_CONTEXT;
        else if (prot_bad) st = gpdb_pkg::ST_BAD_PROT;
        else if (pa_mis)   st = gpdb_pkg::ST_MISALIGNED;
        else if (pa_oor)   st = gpdb_pkg::ST_OUT_OF_RANGE;
        else               desc = pa_q | leaf;
      end
      gpdb_pkg::OP_TABLE: begin
        if (pa_mis)      st = gpdb_pkg::ST_MISALIGNED;
        else if (pa_oor) st = gpdb_pkg::ST_OUT_OF_RANGE;
        else             desc = pa_q | AW'(gpdb_pkg::TypeBits);
      end
      gpdb_pkg::OP_BASE: begin
        if (ctx_bad)     st = gpdb_pkg::ST_BAD_CONTEXT;
        else if (pa_mis) st = gpdb_pkg::ST_MISALIGNED;
        else if (pa_oor) st = gpdb_pkg::ST_OUT_OF_RANGE;
        else if (hi_mis) st = gpdb_pkg::ST_MISALIGNED;
        else if (hi_oor) st = gpdb_pkg::ST_OUT_OF_RANGE;
        else begin
          desc    = asid | pa_q | AW'(gpdb_pkg::BaseValid);
          hi_word = asid | pa_hi_q | AW'(gpdb_pkg::BaseValid);
        end
      end
      gpdb_pkg::OP_VALIDATE: begin
        if (len_q == '0)                st = gpdb_pkg::ST_INVALID;
        else if (ctx_bad)               st = gpdb_pkg::ST_BAD_CONTEXT;
        else if (prot_bad)              st = gpdb_pkg::ST_BAD_PROT;
        else if (rng_mis)               st = gpdb_pkg::ST_MISALIGNED;
        else if (wrap)                  st = gpdb_pkg::ST_OVERFLOW;
        else if (pa_oor || pa_end_oor)  st = gpdb_pkg::ST_OUT_OF_RANGE;
        else if (va_low && end_low)     half = 1'b0;
        else if (va_high)               half = 1'b1;
        else                            st = gpdb_pkg::ST_OUT_OF_RANGE;
      end
      default: st = gpdb_pkg::ST_INVALID;
    endcase
  end

  // Result register
  gpdb_pkg::status_e st_q;
  logic [AW-1:0]     desc_q, hi_word_q;
  logic              half_q;

  always_ff @(posedge clk_i) begin
    if (out_adv && in_valid_q) begin
      st_q      <= st;
      desc_q    <= desc;
      hi_word_q <= hi_word;
      half_q    <= half;
    end
  end

  assign m_axis_tdata = {7'd0, half_q, hi_word_q, desc_q};
  assign m_axis_tuser = st_q;

endmodule
`default_nettype wire

@@ bench/tb_gpu_page_descriptor_builder.sv @@
// Self-checking testbench for the translation-table word builder.
`timescale 1ns / 1ps

module tb_gpu_page_descriptor_builder;
  import gpdb_pkg::*;

  localparam logic [63:0] PAGE_SIZE    = 64'd1 << PAGE_BITS;
  localparam logic [63:0] PAGE_MASK    = PAGE_SIZE - 64'd1;
  localparam logic [63:0] PHYS_LIMIT   = 64'd1 << OUTPUT_ADDRESS_BITS;
  localparam logic [63:0] VA_LOW_LIMIT = 64'd1 << INPUT_ADDRESS_BITS;
  localparam logic [63:0] VA_HIGH_BASE = ~(VA_LOW_LIMIT - 64'd1);
  localparam int          IDLE_PCT     = 29;

  typedef struct packed {
    op_e         op;
    logic [7:0]  ctx;
    logic [3:0]  prot;
    logic [63:0] pa;
    logic [63:0] pa_hi;
    logic [63:0] va;
    logic [63:0] len;
  } map_req_t;

  typedef struct packed {
    status_e     status;
    logic [63:0] desc;
    logic [63:0] high_word;
    logic        half;
  } table_word_t;

  logic           clk_i         = 1'b0;
  logic           rst_ni        = 1'b0;
  logic           cfg_wr_en_i   = 1'b0;
  logic [7:0]     cfg_wr_data_i = '0;
  logic           s_axis_tvalid = 1'b0;
  logic           s_axis_tready;
  logic [271:0]   s_axis_tdata  = '0;
  logic [1:0]     s_axis_tuser  = '0;
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  logic [135:0]   m_axis_tdata;
  logic [2:0]     m_axis_tuser;

  table_word_t    pending_words[$];
  logic [7:0]     fw_ctx_model   = '0;
  int             error_count    = 0;
  bit             quiet_mode     = 1'b0;
  int             hold_request   = 0;
  int             stall_left     = 0;

  gpu_page_descriptor_builder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("gpu_page_descriptor_builder test failed");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  // Packed as {attr[1:0], ap[1:0], uxn, pxn}.
  function automatic logic [5:0] prot_class(input logic [2:0] cls);
    case (cls)
      3'd0:    return 6'b01_01_1_0;
      3'd1:    return 6'b10_01_1_0;
      3'd2:    return 6'b00_01_1_0;
      3'd3:    return 6'b00_00_1_1;
      3'd4:    return 6'b00_01_1_1;
      3'd5:    return 6'b10_10_0_0;
      3'd6:    return 6'b10_10_0_1;
      default: return 6'b10_10_1_0;
    endcase
  endfunction

  function automatic status_e leaf_attrs(input logic [7:0] ctx, input logic [3:0] prot,
                                         output logic [63:0] bits);
    logic       fw;
    logic [5:0] cls;
    bits = '0;
    if (ctx >= CONTEXT_COUNT) return ST_BAD_CONTEXT;
    if (prot > 4'd7) return ST_BAD_PROT;
    fw = (ctx == fw_ctx_model);
    // Firmware classes belong to the firmware context only, GPU classes to all others.
    if ((fw && prot >= 4'd5) || (!fw && prot <= 4'd4)) return ST_BAD_PROT;
    cls = prot_class(prot[2:0]);
    bits[BitOwner] = 1'b1;
    bits[BitAf]    = 1'b1;
    bits[BitUxn]   = cls[1];
    bits[BitPxn]   = cls[0];
    bits[BitNg]    = !fw;
    bits[7:6]      = cls[3:2];
    bits[3:2]      = cls[5:4];
    bits[1:0]      = TypeBits;
    return ST_OK;
  endfunction

  function automatic status_e addr_status(input logic [63:0] pa);
    if ((pa & PAGE_MASK) != 64'd0) return ST_MISALIGNED;
    if (pa >= PHYS_LIMIT) return ST_OUT_OF_RANGE;
    return ST_OK;
  endfunction

  function automatic table_word_t predict_word(input map_req_t r);
    table_word_t w;
    status_e     st;
    logic [63:0] bits;
    logic [63:0] asid;
    logic [63:0] last;
    logic        half;
    w    = '0;
    half = 1'b0;
    case (r.op)
      OP_PAGE: begin
        st = leaf_attrs(r.ctx, r.prot, bits);
        if (st == ST_OK) st = addr_status(r.pa);
        if (st == ST_OK) w.desc = r.pa | bits;
      end
      OP_TABLE: begin
        st = addr_status(r.pa);
        if (st == ST_OK) w.desc = r.pa | {62'd0, TypeBits};
      end
      OP_BASE: begin
        if (r.ctx >= CONTEXT_COUNT) begin
          st = ST_BAD_CONTEXT;
        end else begin
          st = addr_status(r.pa);
          if (st == ST_OK) st = addr_status(r.pa_hi);
        end
        if (st == ST_OK) begin
          asid        = {56'd0, r.ctx} << AsidShift;
          w.desc      = asid | r.pa | {63'd0, BaseValid};
          w.high_word = asid | r.pa_hi | {63'd0, BaseValid};
        end
      end
      default: begin
        if (r.len == 64'd0) begin
          st = ST_INVALID;
        end else begin
          st = leaf_attrs(r.ctx, r.prot, bits);
          if (st == ST_OK && ((r.va | r.pa | r.len) & PAGE_MASK) != 64'd0) st = ST_MISALIGNED;
          // The last byte must not wrap past the top of the address space.
          if (st == ST_OK && (r.len - 64'd1) > ~r.va) st = ST_OVERFLOW;
          if (st == ST_OK && (r.pa >= PHYS_LIMIT || r.len > PHYS_LIMIT - r.pa))
            st = ST_OUT_OF_RANGE;
          if (st == ST_OK) begin
            last = r.va + (r.len - 64'd1);
            if (r.va < VA_LOW_LIMIT && last < VA_LOW_LIMIT) half = 1'b0;
            else if (r.va >= VA_HIGH_BASE) half = 1'b1;
            else st = ST_OUT_OF_RANGE;
          end
        end
        if (st == ST_OK) w.half = half;
      end
    endcase
    w.status = st;
    return w;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at %0t: %s got %h, wanted %h", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin : result_check
    table_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("result transfer with no request pending", m_axis_tdata[63:0], '0);
      end else begin
        want = pending_words.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch("status", {61'd0, m_axis_tuser}, {61'd0, want.status});
        if (m_axis_tdata[63:0] !== want.desc)
          report_mismatch("descriptor", m_axis_tdata[63:0], want.desc);
        if (m_axis_tdata[127:64] !== want.high_word)
          report_mismatch("high base word", m_axis_tdata[127:64], want.high_word);
        if (m_axis_tdata[128] !== want.half)
          report_mismatch("half", {63'd0, m_axis_tdata[128]}, {63'd0, want.half});
      end
    end
  end

  // ---------------------------------------------------------------- driving

  // Output side: random stalls, always ready in quiet mode, or a counted hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_request > 0) begin
      stall_left   = hold_request;
      hold_request = 0;
    end
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (quiet_mode) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_req(input map_req_t r);
    int gap;
    // Outside quiet mode each cycle idles with the same chance, so the idle share of cycles matches IDLE_PCT.
    gap = 0;
    while (!quiet_mode && $urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, r.len, r.va, r.pa_hi, r.pa, r.prot, r.ctx};
    s_axis_tuser  <= r.op;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_words.push_back(predict_word(r));
  endtask

  task automatic wait_results_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_fw_context(input logic [7:0] value);
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    fw_ctx_model = value;
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic map_req_t mk(input op_e op, input logic [7:0] ctx, input logic [3:0] prot,
                                  input logic [63:0] pa, input logic [63:0] pa_hi,
                                  input logic [63:0] va, input logic [63:0] len);
    map_req_t r;
    r = '{op: op, ctx: ctx, prot: prot, pa: pa, pa_hi: pa_hi, va: va, len: len};
    return r;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] phys_page();
    return rand_word() & (PHYS_LIMIT - 64'd1) & ~PAGE_MASK;
  endfunction

  // Mostly well-formed requests so that the later checks are reached; the rest is noise.
  function automatic map_req_t make_req(input bit clean);
    map_req_t    r;
    logic [63:0] pages;
    logic [63:0] va_off;
    pages  = 64'($urandom_range(1, 16));
    va_off = rand_word() & (VA_LOW_LIMIT - 64'd1) & ~PAGE_MASK;
    r.op   = op_e'($urandom_range(3));

    if (clean || $urandom_range(99) < 80) begin
      if (fw_ctx_model < CONTEXT_COUNT && $urandom_range(2) == 0) begin
        r.ctx = fw_ctx_model;
      end else begin
        r.ctx = 8'($urandom_range(CONTEXT_COUNT - 1));
        if (r.ctx == fw_ctx_model) r.ctx = 8'((r.ctx + 1) % CONTEXT_COUNT);
      end
    end else begin
      r.ctx = 8'($urandom_range(255));
    end

    if (clean || $urandom_range(99) < 85)
      r.prot = (r.ctx == fw_ctx_model) ? 4'($urandom_range(4)) : 4'($urandom_range(5, 7));
    else
      r.prot = 4'($urandom_range(15));

    case ($urandom_range(9))
      7:       r.pa = PHYS_LIMIT - pages * PAGE_SIZE;
      8:       r.pa = clean ? pages * PAGE_SIZE : rand_word();
      9:       r.pa = clean ? phys_page() : phys_page() + 64'($urandom_range(1, 3)) * PHYS_LIMIT;
      default: r.pa = phys_page();
    endcase
    r.pa_hi = (clean || $urandom_range(3) != 0) ? phys_page() : rand_word();

    case ($urandom_range(9))
      4, 5, 6: r.va = VA_HIGH_BASE | va_off;
      7:       r.va = VA_LOW_LIMIT - pages * PAGE_SIZE;
      8:       r.va = 64'd0 - pages * PAGE_SIZE;
      9:       r.va = clean ? va_off : rand_word();
      default: r.va = va_off;
    endcase

    case ($urandom_range(19))
      16:      r.len = rand_word() & ~PAGE_MASK;
      17:      r.len = clean ? pages * PAGE_SIZE : 64'd0;
      18:      r.len = clean ? PAGE_SIZE : rand_word();
      19:      r.len = clean ? 64'd16 * PAGE_SIZE
                             : pages * PAGE_SIZE + 64'($urandom_range(1, 1 << PAGE_BITS));
      default: r.len = pages * PAGE_SIZE;
    endcase
    return r;
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_req(make_req($urandom_range(99) < 80));
  endtask

  // ---------------------------------------------------------------- tests

  // Firmware context is zero out of reset.
  task automatic test_directed_cases();
    logic [63:0] top;
    top = PHYS_LIMIT - PAGE_SIZE;
    send_req(mk(OP_PAGE, 8'd0, 4'd0, PAGE_SIZE, '0, '0, '0));
    send_req(mk(OP_PAGE, 8'd5, 4'd7, top, '0, '0, '0));
    send_req(mk(OP_PAGE, 8'd64, 4'd5, PAGE_SIZE, '0, '0, '0));
    send_req(mk(OP_PAGE, 8'd255, 4'd15, '1, '1, '1, '1));
    send_req(mk(OP_PAGE, 8'd1, 4'd8, PAGE_SIZE, '0, '0, '0));
    // Firmware class on a GPU context, then a GPU class on the firmware context.
    send_req(mk(OP_PAGE, 8'd1, 4'd2, PAGE_SIZE, '0, '0, '0));
    send_req(mk(OP_PAGE, 8'd0, 4'd6, PAGE_SIZE, '0, '0, '0));
    send_req(mk(OP_PAGE, 8'd0, 4'd4, PAGE_SIZE + 64'd1, '0, '0, '0));
    send_req(mk(OP_PAGE, 8'd3, 4'd5, PHYS_LIMIT, '0, '0, '0));
    send_req(mk(OP_TABLE, 8'd0, 4'd0, 64'd0, '0, '0, '0));
    send_req(mk(OP_TABLE, 8'd0, 4'd0, '1, '0, '0, '0));
    send_req(mk(OP_TABLE, 8'd0, 4'd0, ~PAGE_MASK, '0, '0, '0));
    send_req(mk(OP_BASE, 8'd63, 4'd0, PAGE_SIZE, top, '0, '0));
    send_req(mk(OP_BASE, 8'd64, 4'd0, PAGE_SIZE, top, '0, '0));
    send_req(mk(OP_BASE, 8'd0, 4'd0, PAGE_MASK, top, '0, '0));
    send_req(mk(OP_BASE, 8'd2, 4'd0, PAGE_SIZE, PHYS_LIMIT, '0, '0));
    // Zero length wins over every other check.
    send_req(mk(OP_VALIDATE, 8'd255, 4'd15, '1, '0, '1, 64'd0));
    send_req(mk(OP_VALIDATE, 8'd70, 4'd5, '0, '0, '0, PAGE_SIZE));
    send_req(mk(OP_VALIDATE, 8'd0, 4'd3, '0, '0, '0, PAGE_SIZE + 64'd1));
    send_req(mk(OP_VALIDATE, 8'd9, 4'd5, '0, '0, 64'd0 - PAGE_SIZE, 2 * PAGE_SIZE));
    send_req(mk(OP_VALIDATE, 8'd9, 4'd6, top, '0, '0, 2 * PAGE_SIZE));
    send_req(mk(OP_VALIDATE, 8'd9, 4'd7, '0, '0, VA_LOW_LIMIT - 2 * PAGE_SIZE, 2 * PAGE_SIZE));
    send_req(mk(OP_VALIDATE, 8'd9, 4'd7, '0, '0, VA_LOW_LIMIT - PAGE_SIZE, 2 * PAGE_SIZE));
    send_req(mk(OP_VALIDATE, 8'd0, 4'd1, top, '0, VA_HIGH_BASE, PAGE_SIZE));
    send_req(mk(OP_VALIDATE, 8'd0, 4'd0, '0, '0, 64'd0 - PAGE_SIZE, PAGE_SIZE));
    send_req(mk(OP_VALIDATE, 8'd9, 4'd5, '0, '0, VA_LOW_LIMIT, PAGE_SIZE));
  endtask

  task automatic test_firmware_context_sweep();
    logic [7:0] settings[5];
    settings = '{8'd255, 8'd63, 8'd200, 8'd17, 8'd0};
    foreach (settings[i]) begin
      wait_results_drained();
      write_fw_context(settings[i]);
      // With the firmware context out of reach, every valid context takes GPU classes.
      if (settings[i] >= CONTEXT_COUNT) begin
        send_req(mk(OP_PAGE, 8'd0, 4'd0, PAGE_SIZE, '0, '0, '0));
        send_req(mk(OP_PAGE, 8'd0, 4'd5, PAGE_SIZE, '0, '0, '0));
      end
      send_random(50);
    end
  endtask

  // The receiver stops for a long stretch while the sender keeps offering requests.
  task automatic test_output_backpressure();
    wait_results_drained();
    quiet_mode   = 1'b1;
    hold_request = 60;
    send_random(40);
    wait_results_drained();
    quiet_mode = 1'b0;
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      wait_results_drained();
      if ($urandom_range(1) == 0) write_fw_context(8'($urandom_range(CONTEXT_COUNT - 1)));
      else write_fw_context(8'($urandom_range(255)));
      // The middle phase runs back to back on both sides.
      quiet_mode = (phase == 1);
      send_random(85);
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_firmware_context_sweep();
    test_output_backpressure();
    test_random_traffic();
    wait_results_drained();
    repeat (8) @(posedge clk_i);

    if (error_count == 0) begin
      $display("gpu_page_descriptor_builder test passed");
    end else begin
      $display("gpu_page_descriptor_builder test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/gpdb_pkg.sv
rtl/gpu_page_descriptor_builder.sv
bench/tb_gpu_page_descriptor_builder.sv
